// File: hdl/kfli_pkg.sv
// Shared types and constants of the keyframe linear interpolator.
// No dependencies; the top level, front end and back end import this package.
package kfli_pkg;

  localparam int unsigned MAX_KEYS_DEF     = 16;
  localparam int unsigned NUM_CHANNELS_DEF = 4;

  localparam int unsigned IO_CH      = 4;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned KCNT_W     = 5;
  localparam int unsigned CCNT_W     = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CMD_DEPTH  = 2;

  localparam logic [KCNT_W-1:0] KEY_COUNT_RST     = KCNT_W'(0);
  localparam logic [CCNT_W-1:0] CHANNEL_COUNT_RST = CCNT_W'(4);

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_COUNT     = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } reg_idx_e;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    action_e                 action;
    logic [SLOT_W-1:0]       slot;
    logic [TIME_W-1:0]       stamp;
    val_t [IO_CH-1:0]        values;
  } cmd_t;

  typedef struct packed {
    logic [KCNT_W-1:0] key_count;
    logic [CCNT_W-1:0] channel_count;
  } cfg_t;

endpackage

// File: hdl/keyframe_linear_interpolator.sv
// Top level of the keyframe linear interpolator: configuration registers,
// front end queue and back end sequencer. Depends on kfli_pkg, kfli_front, kfli_back.
//
// Keyframes (a 32-bit time and up to four Q8.8 values) are loaded by write words and
// sampled by sample words; each sample gives one result word, writes give none. The
// front end queues up to two words, so pushes continue while a result waits on pop.
// In the back end a write is stored in the key stores when it is taken. A sample that
// clamps to the first or last key checks the end keys and copies that key's values;
// one that falls between keys also searches the time memory at one entry per cycle on
// its single read port, forms a 16-bit fraction in the divider at one fraction bit per
// cycle, and scales each of up to four channels in the shared multiplier at one channel
// per cycle. The key stores come up undefined; sample only entries that were written.
module keyframe_linear_interpolator import kfli_pkg::*; #(
  parameter int unsigned MAX_KEYS     = MAX_KEYS_DEF,
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic                  action_i,
  input  logic [SLOT_W-1:0]     entry_index_i,
  input  logic [TIME_W-1:0]     entry_time_i,
  input  logic signed [VAL_W-1:0] entry_value_0_i,
  input  logic signed [VAL_W-1:0] entry_value_1_i,
  input  logic signed [VAL_W-1:0] entry_value_2_i,
  input  logic signed [VAL_W-1:0] entry_value_3_i,
  input  logic [TIME_W-1:0]     sample_time_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  status_o,
  output logic signed [VAL_W-1:0] out_value_0_o,
  output logic signed [VAL_W-1:0] out_value_1_o,
  output logic signed [VAL_W-1:0] out_value_2_o,
  output logic signed [VAL_W-1:0] out_value_3_o
);

  cfg_t             cfg_q;
  val_t [IO_CH-1:0] entry_values;
  val_t [IO_CH-1:0] out_values;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_count     <= KEY_COUNT_RST;
      cfg_q.channel_count <= CHANNEL_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_KEY_COUNT:     cfg_q.key_count     <= cfg_data_i[KCNT_W-1:0];
        REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data_i[CCNT_W-1:0];
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  assign entry_values = {entry_value_3_i, entry_value_2_i, entry_value_1_i, entry_value_0_i};

  kfli_front #(.MAX_KEYS(MAX_KEYS)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .action_i       (action_i),
    .entry_index_i  (entry_index_i),
    .entry_time_i   (entry_time_i),
    .entry_values_i (entry_values),
    .sample_time_i  (sample_time_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  kfli_back #(.MAX_KEYS(MAX_KEYS), .NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .cfg_i        (cfg_q),
    .empty        (empty),
    .pop          (pop),
    .status_o     (status_o),
    .out_values_o (out_values)
  );

  assign out_value_0_o = out_values[0];
  assign out_value_1_o = out_values[1];
  assign out_value_2_o = out_values[2];
  assign out_value_3_o = out_values[3];

endmodule

// File: hdl/kfli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the key time and key value stores.
module kfli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/kfli_front.sv
// Front end: classifies and queues input words; drops writes to slots past MAX_KEYS.
// Depends on kfli_pkg; feeds kfli_back.
module kfli_front import kfli_pkg::*; #(
  parameter int unsigned MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               action_i,
  input  logic [SLOT_W-1:0]  entry_index_i,
  input  logic [TIME_W-1:0]  entry_time_i,
  input  val_t [IO_CH-1:0]   entry_values_i,
  input  logic [TIME_W-1:0]  sample_time_i,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_pop_i
);

  localparam int unsigned CQ_AW = $clog2(CMD_DEPTH);

  cmd_t             q_mem_q [CMD_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_q;
  logic [CQ_AW-1:0] rd_ptr_q;
  logic [CQ_AW:0]   count_q;

  cmd_t cmd_in;
  logic slot_ok;
  logic accept;
  logic keep;
  logic pop_en;

  assign full        = (count_q == (CQ_AW+1)'(CMD_DEPTH));
  assign accept      = push && !full;
  assign slot_ok     = (32'(entry_index_i) < MAX_KEYS);
  assign keep        = accept && ((action_e'(action_i) == ACT_SAMPLE) || slot_ok);
  assign cmd_valid_o = (count_q != '0);
  assign pop_en      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    cmd_in.action = action_e'(action_i);
    cmd_in.slot   = entry_index_i;
    cmd_in.stamp  = (action_e'(action_i) == ACT_SAMPLE) ? sample_time_i : entry_time_i;
    cmd_in.values = entry_values_i;
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (keep) begin
        wr_ptr_q <= wr_ptr_q + CQ_AW'(1);
      end
      if (pop_en) begin
        rd_ptr_q <= rd_ptr_q + CQ_AW'(1);
      end
      unique case ({keep, pop_en})
        2'b10:   count_q <= count_q + (CQ_AW+1)'(1);
        2'b01:   count_q <= count_q - (CQ_AW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: hdl/kfli_back.sv
// Back end: key stores, search sequencer, serial divider, shared multiplier, result word.
// Depends on kfli_pkg and kfli_ram; takes commands from kfli_front.
module kfli_back import kfli_pkg::*; #(
  parameter int unsigned MAX_KEYS     = MAX_KEYS_DEF,
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  input  cfg_t             cfg_i,
  output logic             empty,
  input  logic             pop,
  output logic             status_o,
  output val_t [IO_CH-1:0] out_values_o
);

  localparam int unsigned OUT_CH = (NUM_CHANNELS < IO_CH) ? NUM_CHANNELS : IO_CH;
  localparam int unsigned KEY_AW = $clog2(MAX_KEYS);
  localparam int unsigned NW     = $clog2(MAX_KEYS + 1);
  localparam int unsigned ROW_W  = OUT_CH * VAL_W;
  localparam int unsigned CNT_W  = $clog2(OUT_CH + 1);
  localparam int unsigned DIV_CW = $clog2(FRAC_W);
  localparam int unsigned PROD_W = VAL_W + FRAC_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK0,
    ST_CHKL,
    ST_SCAN,
    ST_COPY,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [TIME_W-1:0]   s_q;
  logic [TIME_W-1:0]   prev_q;
  logic [KEY_AW-1:0]   idx_q;
  logic [KEY_AW-1:0]   k_q;
  logic [TIME_W-1:0]   rem_q;
  logic [TIME_W-1:0]   den_q;
  logic [FRAC_W-1:0]   quo_q;
  logic [DIV_CW-1:0]   dcnt_q;
  logic [CNT_W-1:0]    mcnt_q;
  logic                status_q;
  val_t                v0_q  [OUT_CH];
  val_t                v1_q  [OUT_CH];
  val_t                res_q [IO_CH];
  logic                out_valid_q;
  logic                out_status_q;
  val_t                out_val_q [IO_CH];

  logic [NW-1:0]       n_eff;
  logic [KEY_AW-1:0]   last_idx;
  logic [CCNT_W-1:0]   used_ch;

  logic                wr_en;
  logic [KEY_AW-1:0]   wr_addr;
  logic [ROW_W-1:0]    wr_row;
  logic [KEY_AW-1:0]   t_raddr;
  logic [KEY_AW-1:0]   v_raddr;
  logic [TIME_W-1:0]   t_rdata;
  logic [ROW_W-1:0]    v_rdata;

  logic [TIME_W:0]     r2;
  logic [TIME_W-1:0]   rem_next;
  logic                qbit;

  logic signed [VAL_W:0]    diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] num;
  logic signed [PROD_W-1:0] quot;
  val_t                     lane;

  always_comb begin
    if (32'(cfg_i.key_count) > MAX_KEYS) begin
      n_eff = NW'(MAX_KEYS);
    end else begin
      n_eff = NW'(cfg_i.key_count);
    end
    last_idx = KEY_AW'(n_eff - NW'(1));
    if (32'(cfg_i.channel_count) > OUT_CH) begin
      used_ch = CCNT_W'(OUT_CH);
    end else begin
      used_ch = cfg_i.channel_count;
    end
  end

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign wr_en     = cmd_pop_o && (cmd_i.action == ACT_WRITE);
  assign wr_addr   = KEY_AW'(cmd_i.slot);

  always_comb begin
    for (int j = 0; j < OUT_CH; j++) begin
      wr_row[VAL_W*j +: VAL_W] = cmd_i.values[j];
    end
  end

  always_comb begin
    unique case (state_q)
      ST_CHK0: t_raddr = last_idx;
      ST_CHKL: t_raddr = KEY_AW'(1);
      ST_SCAN: t_raddr = idx_q + KEY_AW'(1);
      default: t_raddr = '0;
    endcase
    unique case (state_q)
      ST_CHK0: v_raddr = '0;
      ST_CHKL: v_raddr = last_idx;
      ST_SCAN: v_raddr = (t_rdata == s_q) ? idx_q : idx_q - KEY_AW'(1);
      default: v_raddr = k_q;
    endcase
  end

  kfli_ram #(.WIDTH(TIME_W), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (cmd_i.stamp),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  kfli_ram #(.WIDTH(ROW_W), .DEPTH(MAX_KEYS)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_row),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  always_comb begin
    r2 = {rem_q, 1'b0};
    if (r2 >= {1'b0, den_q}) begin
      qbit     = 1'b1;
      rem_next = TIME_W'(r2 - {1'b0, den_q});
    end else begin
      qbit     = 1'b0;
      rem_next = r2[TIME_W-1:0];
    end
  end

  always_comb begin
    diff = {v1_q[0][VAL_W-1], v1_q[0]} - {v0_q[0][VAL_W-1], v0_q[0]};
    prod = PROD_W'(diff * $signed({1'b0, quo_q}));
    num  = prod + $signed({{2{v0_q[0][VAL_W-1]}}, v0_q[0], {FRAC_W{1'b0}}});
    quot = num >>> FRAC_W;
    if (num[PROD_W-1] && (num[FRAC_W-1:0] != '0)) begin
      quot = quot + PROD_W'(1);
    end
    lane = quot[VAL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      s_q          <= '0;
      prev_q       <= '0;
      idx_q        <= '0;
      k_q          <= '0;
      rem_q        <= '0;
      den_q        <= '0;
      quo_q        <= '0;
      dcnt_q       <= '0;
      mcnt_q       <= '0;
      status_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= 1'b0;
      for (int j = 0; j < OUT_CH; j++) begin
        v0_q[j] <= '0;
        v1_q[j] <= '0;
      end
      for (int j = 0; j < IO_CH; j++) begin
        res_q[j]     <= '0;
        out_val_q[j] <= '0;
      end
    end else begin
      if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i && (cmd_i.action == ACT_SAMPLE)) begin
            s_q <= cmd_i.stamp;
            if (n_eff == '0) begin
              status_q <= 1'b1;
              state_q  <= ST_DONE;
            end else begin
              status_q <= 1'b0;
              state_q  <= ST_CHK0;
            end
          end
        end
        ST_CHK0: begin
          prev_q <= t_rdata;
          if ((n_eff == NW'(1)) || (t_rdata >= s_q)) begin
            state_q <= ST_COPY;
          end else begin
            state_q <= ST_CHKL;
          end
        end
        ST_CHKL: begin
          if (t_rdata <= s_q) begin
            state_q <= ST_COPY;
          end else begin
            idx_q   <= KEY_AW'(1);
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (t_rdata >= s_q) begin
            k_q <= idx_q;
            if (t_rdata == s_q) begin
              state_q <= ST_COPY;
            end else begin
              rem_q   <= s_q - prev_q;
              den_q   <= t_rdata - prev_q;
              dcnt_q  <= '0;
              state_q <= ST_DIV;
            end
          end else begin
            prev_q <= t_rdata;
            idx_q  <= idx_q + KEY_AW'(1);
          end
        end
        ST_COPY: begin
          for (int j = 0; j < OUT_CH; j++) begin
            res_q[j] <= v_rdata[VAL_W*j +: VAL_W];
          end
          state_q <= ST_DONE;
        end
        ST_DIV: begin
          rem_q <= rem_next;
          quo_q <= {quo_q[FRAC_W-2:0], qbit};
          if (dcnt_q == DIV_CW'(0)) begin
            for (int j = 0; j < OUT_CH; j++) begin
              v0_q[j] <= v_rdata[VAL_W*j +: VAL_W];
            end
          end
          if (dcnt_q == DIV_CW'(1)) begin
            for (int j = 0; j < OUT_CH; j++) begin
              v1_q[j] <= v_rdata[VAL_W*j +: VAL_W];
            end
          end
          if (dcnt_q == DIV_CW'(FRAC_W - 1)) begin
            mcnt_q  <= '0;
            state_q <= ST_MUL;
          end else begin
            dcnt_q <= dcnt_q + DIV_CW'(1);
          end
        end
        ST_MUL: begin
          for (int j = 0; j < OUT_CH - 1; j++) begin
            v0_q[j]  <= v0_q[j+1];
            v1_q[j]  <= v1_q[j+1];
            res_q[j] <= res_q[j+1];
          end
          v0_q[OUT_CH-1]  <= v0_q[0];
          v1_q[OUT_CH-1]  <= v1_q[0];
          res_q[OUT_CH-1] <= lane;
          if (mcnt_q == CNT_W'(OUT_CH - 1)) begin
            state_q <= ST_DONE;
          end else begin
            mcnt_q <= mcnt_q + CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (!out_valid_q) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            for (int j = 0; j < IO_CH; j++) begin
              if (!status_q && (CCNT_W'(j) < used_ch)) begin
                out_val_q[j] <= res_q[j];
              end else begin
                out_val_q[j] <= '0;
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign empty    = !out_valid_q;
  assign status_o = out_status_q;

  always_comb begin
    for (int j = 0; j < IO_CH; j++) begin
      out_values_o[j] = out_val_q[j];
    end
  end

endmodule
